### rtl/core/hex_frame_shunt_parser_defines.svh
// assertion macros for the frame parser rtl
// used by every rtl file that asserts; no other dependencies
`ifndef HEX_FRAME_SHUNT_PARSER_DEFINES_SVH
`define HEX_FRAME_SHUNT_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define HFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HFS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/hfs_pkg.sv
// shared types and constants for the frame parser
// no dependencies
`timescale 1ns / 1ps
package hfs_pkg;
  localparam int FRAME_LENGTH = 38;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [7:0] START_BYTE = 8'h3A;
  localparam logic [5:0] VOLT_OFFSET = 6'd11;
  localparam logic [5:0] CURR_OFFSET = 6'd19;
  localparam logic [5:0] LAST_POS = 6'(FRAME_LENGTH - 1);
  localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic [2:0] ADDR_TIMEOUT = 3'd0;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] voltage_bits;
    logic [31:0] current_bits;
    logic [31:0] power_bits;
    logic        frame_status;
  } out_t;

  // pair of words handed to the multiplier
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        bad;
  } mul_req_t;
endpackage

### rtl/core/hex_frame_shunt_parser.sv
// top level: uart frame parser with timeout and float product
// depends on hfs_pkg, hfs_fmul and the assertion macro header
// the result of a frame goes through the 3-stage multiplier, then the output fifo
// throughput: one beat per cycle while in_ready is high
// reset: synchronous, rst high clears frame position, idle count and queue state
`timescale 1ns / 1ps
`include "hex_frame_shunt_parser_defines.svh"
module hex_frame_shunt_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hfs_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hfs_pkg::out_t  out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  logic [15:0] timeout_ms;
  logic [5:0]  frame_position;
  logic [31:0] voltage_shift, current_shift;
  logic        digit_error;
  logic [15:0] idle_count;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr == hfs_pkg::ADDR_TIMEOUT) ? {16'd0, timeout_ms} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= hfs_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr == hfs_pkg::ADDR_TIMEOUT) begin
      timeout_ms <= pwdata[15:0];
    end
  end

  // result queue: frames are rare, the pipeline plus a 4-entry fifo never overflow
  // as long as we stop taking input while the fifo might fill
  logic        fifo_wr;
  hfs_pkg::out_t fifo_wdata;
  hfs_pkg::out_t fifo_mem [4];
  logic [1:0]  wptr, rptr;
  logic [2:0]  count;
  logic [2:0]  inflight;
  logic        accept, out_fire, launch;

  assign out_fire = out_valid && out_ready;
  // room for the queue contents plus whatever is in the multiplier
  assign in_ready = (3'(count + inflight) < 3'd4) || (count == 3'd0 && inflight == 3'd0);
  assign accept = in_valid && in_ready;

  // digit decode
  logic [7:0] c;
  logic [3:0] nib;
  logic       nib_bad;
  logic [5:0] pos_next;
  logic [2:0] d;
  logic [4:0] bitpos;
  logic [31:0] volt_next, curr_next;
  logic        err_next;
  always_comb begin
    c = in_data.rx_byte;
    nib_bad = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) nib = 4'(c - 8'h37);
    else begin
      nib = 4'd0;
      nib_bad = 1'b1;
    end
    volt_next = voltage_shift;
    curr_next = current_shift;
    err_next = digit_error;
    d = 3'd0;
    if (frame_position >= hfs_pkg::VOLT_OFFSET && frame_position < hfs_pkg::CURR_OFFSET) begin
      d = 3'(frame_position - hfs_pkg::VOLT_OFFSET);
    end else begin
      d = 3'(frame_position - hfs_pkg::CURR_OFFSET);
    end
    // first pair lands in the low byte, high nibble first
    bitpos = {d[2:1], 3'b000} + (d[0] ? 5'd0 : 5'd4);
    launch = 1'b0;
    pos_next = frame_position + 6'd1;
    if (frame_position == 6'd0) begin
      volt_next = 32'd0;
      curr_next = 32'd0;
      err_next = 1'b0;
    end else if (frame_position >= hfs_pkg::VOLT_OFFSET
                 && frame_position < hfs_pkg::CURR_OFFSET) begin
      volt_next = voltage_shift | (32'(nib) << bitpos);
      err_next = digit_error | nib_bad;
    end else if (frame_position >= hfs_pkg::CURR_OFFSET
                 && frame_position < 6'(hfs_pkg::CURR_OFFSET + 6'd8)) begin
      curr_next = current_shift | (32'(nib) << bitpos);
      err_next = digit_error | nib_bad;
    end
    if (frame_position == hfs_pkg::LAST_POS) begin
      pos_next = 6'd0;
      launch = 1'b1;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 6'd0;
      idle_count <= 16'd0;
      digit_error <= 1'b0;
      voltage_shift <= 32'd0;
      current_shift <= 32'd0;
    end else if (accept) begin
      if (in_data.command == hfs_pkg::CMD_TICK) begin
        if (idle_count != 16'hFFFF && 16'(idle_count + 16'd1) >= timeout_ms) begin
          frame_position <= 6'd0;
          idle_count <= 16'd0;
        end else if (idle_count == 16'hFFFF && idle_count >= timeout_ms) begin
          frame_position <= 6'd0;
          idle_count <= 16'd0;
        end else if (idle_count != 16'hFFFF) begin
          idle_count <= idle_count + 16'd1;
        end
      end else begin
        idle_count <= 16'd0;
        if (frame_position != 6'd0 || c == hfs_pkg::START_BYTE) begin
          frame_position <= pos_next;
          voltage_shift <= volt_next;
          current_shift <= curr_next;
          digit_error <= err_next;
        end
      end
    end
  end

  logic mul_go;
  hfs_pkg::mul_req_t mul_req;
  assign mul_go = accept && in_data.command == hfs_pkg::CMD_BYTE && launch;
  assign mul_req = '{a: volt_next, b: curr_next, bad: err_next};

  hfs_fmul u_fmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_go),
    .in_req    (mul_req),
    .out_valid (fifo_wr),
    .out_res   (fifo_wdata)
  );

  // count of results inside the multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= 3'(inflight + {2'd0, mul_go} - {2'd0, fifo_wr});
    end
  end

  // output fifo
  always_ff @(posedge clk) begin
    if (fifo_wr) fifo_mem[wptr] <= fifo_wdata;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 2'd0;
      rptr <= 2'd0;
      count <= 3'd0;
    end else begin
      if (fifo_wr) wptr <= wptr + 2'd1;
      if (out_fire) rptr <= rptr + 2'd1;
      count <= 3'(count + {2'd0, fifo_wr} - {2'd0, out_fire});
    end
  end
  assign out_valid = (count != 3'd0);
  assign out_data = fifo_mem[rptr];

  `HFS_ASSERT_IMPL(a_no_overflow, clk, rst, fifo_wr && !out_fire, count < 3'd4)
  `HFS_ASSERT_IMPL(a_no_underflow, clk, rst, out_fire, count != 3'd0)
  `HFS_ASSERT_NEXT(a_frame_done, clk, rst, mul_go, frame_position == 6'd0)
endmodule

### rtl/core/hfs_fmul.sv
// pipelined binary32 multiplier, round to nearest even, with subnormals
// depends on hfs_pkg
`timescale 1ns / 1ps
`include "hex_frame_shunt_parser_defines.svh"
module hfs_fmul (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  hfs_pkg::mul_req_t in_req,
  output logic             out_valid,
  output hfs_pkg::out_t    out_res
);
  // stage 1: classify and normalize
  logic [7:0]  ea, eb;
  logic [22:0] ma, mb;
  logic        za, zb, nana, nanb, infa, infb, sign;
  logic [23:0] na, nb;
  logic [4:0]  lza, lzb;
  logic signed [10:0] ena, enb;
  always_comb begin
    ea = in_req.a[30:23]; eb = in_req.b[30:23];
    ma = in_req.a[22:0];  mb = in_req.b[22:0];
    sign = in_req.a[31] ^ in_req.b[31];
    za = (ea == 8'd0) && (ma == 23'd0);
    zb = (eb == 8'd0) && (mb == 23'd0);
    nana = (ea == 8'hFF) && (ma != 23'd0);
    nanb = (eb == 8'hFF) && (mb != 23'd0);
    infa = (ea == 8'hFF) && (ma == 23'd0);
    infb = (eb == 8'hFF) && (mb == 23'd0);
    lza = 5'd0; lzb = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (ma[i]) lza = 5'(22 - i);
      if (mb[i]) lzb = 5'(22 - i);
    end
    if (ea == 8'd0) begin
      na = {1'b0, ma} << (lza + 5'd1);
      ena = 11'sd0 - 11'(signed'({6'd0, lza}));
    end else begin
      na = {1'b1, ma};
      ena = 11'(signed'({3'd0, ea}));
    end
    if (eb == 8'd0) begin
      nb = {1'b0, mb} << (lzb + 5'd1);
      enb = 11'sd0 - 11'(signed'({6'd0, lzb}));
    end else begin
      nb = {1'b1, mb};
      enb = 11'(signed'({3'd0, eb}));
    end
  end

  logic        s1_valid, s1_sign, s1_special;
  logic [31:0] s1_special_val, s1_a, s1_b;
  logic [23:0] s1_na, s1_nb;
  logic signed [10:0] s1_e;
  logic        s1_bad;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_sign <= sign;
    s1_na <= na;
    s1_nb <= nb;
    s1_e <= ena + enb - 11'sd127;
    s1_a <= in_req.a;
    s1_b <= in_req.b;
    s1_bad <= in_req.bad;
    s1_special <= nana || nanb || infa || infb || za || zb;
    if (nana || nanb || ((infa || infb) && (za || zb))) begin
      s1_special_val <= hfs_pkg::QNAN_BITS;
    end else if (infa || infb) begin
      s1_special_val <= {sign, 8'hFF, 23'd0};
    end else begin
      s1_special_val <= {sign, 31'd0};
    end
  end

  // stage 2: mantissa product
  logic        s2_valid, s2_sign, s2_special, s2_bad;
  logic [31:0] s2_special_val, s2_a, s2_b;
  logic [47:0] s2_p;
  logic signed [10:0] s2_e;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_p <= 48'(s1_na) * 48'(s1_nb);
    s2_sign <= s1_sign;
    s2_special <= s1_special;
    s2_special_val <= s1_special_val;
    s2_e <= s1_e;
    s2_a <= s1_a;
    s2_b <= s1_b;
    s2_bad <= s1_bad;
  end

  // stage 3: normalize, round, pack
  // shifts past 48 always round to zero, so they fold into the flush case
  logic [47:0] p;
  logic signed [10:0] e;
  logic [5:0]  sh;
  logic [47:0] q, rem, half, mask;
  logic [31:0] result;
  always_comb begin
    p = s2_p;
    e = s2_e;
    if (p[47]) e = e + 11'sd1; else p = p << 1;
    if (e >= 11'sd1) sh = 6'd24;
    else if (e < -11'sd23) sh = 6'd63;
    else sh = 6'(11'sd25 - e);
    q = p >> sh;
    mask = (48'd1 << sh) - 48'd1;
    if (sh == 6'd63) mask = '1;
    rem = p & mask;
    half = (sh == 6'd63) ? 48'd0 : (48'd1 << (sh - 6'd1));
    if (sh == 6'd63) begin
      q = 48'd0;
      if (p != 48'd0 && 1'b0) q = 48'd1;
    end else if (rem > half || (rem == half && q[0])) begin
      q = q + 48'd1;
    end
    if (e >= 11'sd1) begin
      if (q[24]) begin
        q = q >> 1;
        e = e + 11'sd1;
      end
      if (e >= 11'sd255) result = {s2_sign, 8'hFF, 23'd0};
      else result = {s2_sign, e[7:0], q[22:0]};
    end else begin
      result = {s2_sign, q[30:0]};
    end
    if (s2_special) result = s2_special_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
    out_res.frame_status <= s2_bad;
    out_res.voltage_bits <= s2_bad ? 32'd0 : s2_a;
    out_res.current_bits <= s2_bad ? 32'd0 : s2_b;
    out_res.power_bits <= s2_bad ? 32'd0 : result;
  end

  `HFS_ASSERT_NEXT(a_pipe_s1, clk, rst, in_valid, s1_valid)
  `HFS_ASSERT_NEXT(a_pipe_s2, clk, rst, s1_valid, s2_valid)
  `HFS_ASSERT_NEXT(a_bad_zero, clk, rst, s2_valid && s2_bad, out_res.power_bits == 32'd0)
endmodule

### dv/tb_hex_frame_shunt_parser.sv
// testbench for the uart hex frame parser: frames, ticks, timeouts and float product
// depends on hfs_pkg and the hex_frame_shunt_parser rtl
`timescale 1ns / 1ps
module tb_hex_frame_shunt_parser;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  hfs_pkg::in_t  in_data;
  logic        out_valid;
  logic        out_ready;
  hfs_pkg::out_t out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hex_frame_shunt_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state, a copy of the block's own
  logic [15:0] timeout_cfg;
  logic [5:0]  frame_pos;
  logic [31:0] volt_word;
  logic [31:0] curr_word;
  logic        digit_bad;
  logic [15:0] tick_count;

  hfs_pkg::out_t frame_results[$];
  int     errors;
  int     quiet_cycles;
  bit     gaps_on;

  localparam int WATCHDOG_LIMIT = 200000;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // round to nearest even on a right shift
  function automatic logic [63:0] rne_shift(logic [63:0] p, int sh);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = p >> sh;
    rem = p & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // binary32 multiply with subnormals
  function automatic logic [31:0] float_mul(logic [31:0] a, logic [31:0] b);
    logic [31:0] sgn;
    int ea;
    int eb;
    int e;
    int sh;
    logic [23:0] ma;
    logic [23:0] mb;
    logic za;
    logic zb;
    logic [63:0] p;
    logic [63:0] q;
    sgn = (a ^ b) & 32'h8000_0000;
    ea = int'(a[30:23]);
    eb = int'(b[30:23]);
    ma = {1'b0, a[22:0]};
    mb = {1'b0, b[22:0]};
    za = (ea == 0) && (ma == 0);
    zb = (eb == 0) && (mb == 0);
    if ((ea == 255 && ma != 0) || (eb == 255 && mb != 0)) return hfs_pkg::QNAN_BITS;
    if (ea == 255 || eb == 255) begin
      if (za || zb) return hfs_pkg::QNAN_BITS;
      return sgn | 32'h7F80_0000;
    end
    if (za || zb) return sgn;
    if (ea == 0) begin
      ea = 1;
      while (!ma[23]) begin
        ma = ma << 1;
        ea--;
      end
    end else ma[23] = 1'b1;
    if (eb == 0) begin
      eb = 1;
      while (!mb[23]) begin
        mb = mb << 1;
        eb--;
      end
    end else mb[23] = 1'b1;
    p = 64'(ma) * 64'(mb);
    e = ea + eb - 127;
    if (p[47]) e++;
    else p = p << 1;
    if (e >= 1) begin
      q = rne_shift(p, 24);
      if (q == (64'd1 << 24)) begin
        q = q >> 1;
        e++;
      end
      if (e >= 255) return sgn | 32'h7F80_0000;
      return sgn | (32'(e) << 23) | (q[31:0] & 32'h007F_FFFF);
    end
    sh = (e < -37) ? 63 : 25 - e;
    q = rne_shift(p, sh);
    return sgn | q[31:0];
  endfunction

  // hex digit value, or 16 when not a digit
  function automatic int digit_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  // advance the predictor by one accepted beat
  task automatic predict_beat(hfs_pkg::in_t beat);
    int nib;
    int d;
    logic [5:0] nxt;
    hfs_pkg::out_t r;
    if (beat.command == hfs_pkg::CMD_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      if (tick_count >= timeout_cfg) begin
        frame_pos = '0;
        tick_count = '0;
      end
      return;
    end
    tick_count = '0;
    if (frame_pos == 0) begin
      if (beat.rx_byte != hfs_pkg::START_BYTE) return;
      volt_word = '0;
      curr_word = '0;
      digit_bad = 1'b0;
    end else if (frame_pos >= hfs_pkg::VOLT_OFFSET && frame_pos < hfs_pkg::VOLT_OFFSET + 8 ||
                 frame_pos >= hfs_pkg::CURR_OFFSET && frame_pos < hfs_pkg::CURR_OFFSET + 8) begin
      nib = digit_value(beat.rx_byte);
      if (nib > 15) begin
        digit_bad = 1'b1;
        nib = 0;
      end
      d = (frame_pos < hfs_pkg::CURR_OFFSET) ? frame_pos - hfs_pkg::VOLT_OFFSET
                                             : frame_pos - hfs_pkg::CURR_OFFSET;
      // first pair of digits is the low byte, high nibble first
      if (frame_pos < hfs_pkg::CURR_OFFSET)
        volt_word |= 32'(nib) << ((d >> 1) * 8 + ((d & 1) ? 0 : 4));
      else
        curr_word |= 32'(nib) << ((d >> 1) * 8 + ((d & 1) ? 0 : 4));
    end
    nxt = frame_pos + 6'd1;
    if (nxt < hfs_pkg::FRAME_LENGTH) begin
      frame_pos = nxt;
      return;
    end
    frame_pos = '0;
    if (digit_bad) r = '{32'd0, 32'd0, 32'd0, 1'b1};
    else r = '{volt_word, curr_word, float_mul(volt_word, curr_word), 1'b0};
    frame_results.push_back(r);
  endtask

  // send one beat, with a random gap in front when allowed
  task automatic send_beat(logic cmd, logic [7:0] b);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = '{cmd, b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat('{cmd, b});
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(hfs_pkg::CMD_BYTE, b);
  endtask

  task automatic send_tick();
    send_beat(hfs_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
  endfunction

  // one frame from two words; bad_digit_at >= 0 spoils that offset
  task automatic send_frame(logic [31:0] v, logic [31:0] c, int bad_digit_at);
    logic [31:0] w;
    logic [7:0] ch;
    int d;
    send_byte(hfs_pkg::START_BYTE);
    for (int p = 1; p < hfs_pkg::FRAME_LENGTH; p++) begin
      if (p >= hfs_pkg::VOLT_OFFSET && p < hfs_pkg::CURR_OFFSET + 8) begin
        w = (p < hfs_pkg::CURR_OFFSET) ? v : c;
        d = (p < hfs_pkg::CURR_OFFSET) ? p - hfs_pkg::VOLT_OFFSET : p - hfs_pkg::CURR_OFFSET;
        ch = hex_char(w[(d >> 1) * 8 + ((d & 1) ? 0 : 4) +: 4]);
      end else ch = 8'($urandom_range(0, 255));
      if (p == bad_digit_at) begin
        case ($urandom_range(0, 3))
          0: ch = 8'("a") + 8'($urandom_range(0, 5));
          1: ch = 8'("G") + 8'($urandom_range(0, 19));
          2: ch = 8'h80 + 8'($urandom_range(0, 127));
          default: ch = hfs_pkg::START_BYTE;
        endcase
      end
      send_byte(ch);
    end
  endtask

  // wait until every expected frame has come out, then let the pipe drain
  task automatic drain();
    while (frame_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == hfs_pkg::ADDR_TIMEOUT) timeout_cfg = val[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 7))
      0: return 32'h7F80_0000 | ($urandom_range(0, 1) << 31);
      1: return 32'h7FC0_0000 | $urandom_range(0, 255);
      2: return $urandom_range(0, 1) << 31;
      3: return $urandom_range(0, 32'h007F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  // edge words, every special float class and a bad digit in each field
  task automatic test_directed_frames();
    send_frame(32'h4150_0000, 32'h4020_0000, -1);
    send_frame(32'h0000_0000, 32'hFFFF_FFFF, -1);
    send_frame(32'hFFFF_FFFF, 32'h0000_0000, -1);
    send_frame(32'h7F80_0000, 32'h0000_0000, -1);
    send_frame(32'h7F7F_FFFF, 32'h7F7F_FFFF, -1);
    send_frame(32'h0000_0001, 32'h3F00_0000, -1);
    send_frame(32'h0080_0000, 32'h3F7F_FFFF, -1);
    send_frame(32'h1234_5678, 32'h9ABC_DEF0, int'(hfs_pkg::VOLT_OFFSET));
    send_frame(32'h1234_5678, 32'h9ABC_DEF0, int'(hfs_pkg::CURR_OFFSET) + 7);
    drain();
  endtask

  // noise while hunting, truncated frame then timeout, then ticks below the timeout
  task automatic test_hunt_and_timeout();
    for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(0, 255)));
    apb_write(hfs_pkg::ADDR_TIMEOUT, 32'd1);
    send_byte(hfs_pkg::START_BYTE);
    for (int i = 0; i < 10; i++) send_byte("5");
    send_tick();
    send_frame(32'h3F80_0000, 32'h4000_0000, -1);
    drain();
    apb_write(hfs_pkg::ADDR_TIMEOUT, 32'd3);
    send_byte(hfs_pkg::START_BYTE);
    send_tick();
    send_tick();
    send_byte("1");
    send_tick();
    send_tick();
    for (int i = 2; i < hfs_pkg::FRAME_LENGTH; i++) send_byte("A");
    drain();
  endtask

  // random frames, broken frames, ticks and noise across timeout settings
  task automatic test_random_traffic(int beats, logic [15:0] tmo);
    int sent;
    int cut;
    int nt;
    apb_write(hfs_pkg::ADDR_TIMEOUT, 32'(tmo));
    sent = 0;
    while (sent < beats) begin
      case ($urandom_range(0, 9))
        0: begin
          send_tick();
          sent++;
        end
        1: begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
        2: begin
          // partial frame then ticks, abandoned only if they reach the timeout
          send_byte(hfs_pkg::START_BYTE);
          cut = $urandom_range(1, hfs_pkg::FRAME_LENGTH - 2);
          nt = $urandom_range(1, 4);
          for (int i = 0; i < cut; i++) send_byte(8'($urandom_range(0, 255)));
          for (int i = 0; i < nt; i++) send_tick();
          sent += cut + 1 + nt;
        end
        3: begin
          send_frame(rand_float(), rand_float(),
                     $urandom_range(hfs_pkg::VOLT_OFFSET, hfs_pkg::CURR_OFFSET + 7));
          sent += hfs_pkg::FRAME_LENGTH;
        end
        default: begin
          send_frame(rand_float(), rand_float(), -1);
          sent += hfs_pkg::FRAME_LENGTH;
        end
      endcase
    end
    drain();
  endtask

  // result checker and receiver stalls
  initial begin
    int stall;
    hfs_pkg::out_t want;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          want = frame_results.pop_front();
          if (out_data.voltage_bits !== want.voltage_bits) begin
            $error("voltage_bits exp %h got %h", want.voltage_bits, out_data.voltage_bits);
            errors++;
          end
          if (out_data.current_bits !== want.current_bits) begin
            $error("current_bits exp %h got %h", want.current_bits, out_data.current_bits);
            errors++;
          end
          if (out_data.power_bits !== want.power_bits) begin
            $error("power_bits exp %h got %h", want.power_bits, out_data.power_bits);
            errors++;
          end
          if (out_data.frame_status !== want.frame_status) begin
            $error("frame_status exp %b got %b", want.frame_status, out_data.frame_status);
            errors++;
          end
        end
      end
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no beat moving either way and no apb access
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL hex_frame_shunt_parser");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    timeout_cfg = hfs_pkg::TIMEOUT_RESET;
    frame_pos = '0;
    volt_word = '0;
    curr_word = '0;
    digit_bad = 1'b0;
    tick_count = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_frames();
    test_hunt_and_timeout();
    test_random_traffic(380, 16'd2);
    test_random_traffic(300, 16'hFFFF);
    test_random_traffic(300, 16'd5);
    // last stretch runs with no idling on either side
    gaps_on = 1'b0;
    test_random_traffic(330, hfs_pkg::TIMEOUT_RESET);

    repeat (20) @(negedge clk);
    if (errors == 0 && frame_results.size() == 0) begin
      $display("PASS hex_frame_shunt_parser");
    end else begin
      $display("FAIL hex_frame_shunt_parser");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/hfs_pkg.sv
rtl/core/hfs_fmul.sv
rtl/core/hex_frame_shunt_parser.sv
dv/tb_hex_frame_shunt_parser.sv
